[hw/rtl/pwl_pkg.sv]
// Shared types and constants for the piecewise linear interpolation table unit.
// Used by every module under hw/rtl; depends on nothing else.
package pwl_pkg;

	localparam int unsigned VAL_W       = 32;
	localparam int unsigned PROD_W      = 2 * VAL_W;
	localparam int unsigned DIV_CNT_W   = $clog2(PROD_W);
	localparam int unsigned COUNT_OUT_W = 9;
	localparam int unsigned DEF_POINT_DEPTH = 256;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_FWD   = 2'd2,
		REQ_INV   = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
	} pwl_req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               hit;
		logic               accepted;
		logic [8:0]         point_count;
		logic               still_monotone;
	} pwl_rsp_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pwl_point_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} pwl_state_t;

endpackage

[hw/rtl/pwl_cell.sv]
// One breakpoint cell of the table chain: holds a single (x,y) point.
// Depends on pwl_pkg for the point type.
module pwl_cell import pwl_pkg::*; (
	input  logic       clk,
	input  logic       load_en,
	input  pwl_point_t load_pt,
	input  logic       shift_en,
	input  pwl_point_t next_pt,
	output pwl_point_t pt
);

	pwl_point_t pt_q;

	// A new point is written only while the chain is at rest, so the two
	// enables never meet.
	always_ff @(posedge clk) begin
		if (load_en) begin
			pt_q <= load_pt;
		end else if (shift_en) begin
			pt_q <= next_pt;
		end
	end

	assign pt = pt_q;

endmodule

[hw/rtl/pwl_muldiv.sv]
// Serial unit for floor(a * m / b) on 32-bit unsigned operands.
// One registered multiply, then one restoring division bit per cycle; uses pwl_pkg.
module pwl_muldiv import pwl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VAL_W-1:0]  a,
	input  logic [VAL_W-1:0]  m,
	input  logic [VAL_W-1:0]  b,
	output logic              done,
	output logic [VAL_W-1:0]  quo
);

	logic [PROD_W-1:0]    prod_q;
	logic [VAL_W-1:0]     b_q;
	logic [VAL_W-1:0]     rem_q;
	logic [VAL_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [VAL_W:0]       rem_nx;
	logic                 ge;

	assign rem_nx = {rem_q, prod_q[PROD_W-1]};
	assign ge     = (rem_nx >= {1'b0, b_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PROD_W'(a) * PROD_W'(m);
			b_q    <= b;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[PROD_W-2:0], 1'b0};
			rem_q  <= ge ? VAL_W'(rem_nx - {1'b0, b_q}) : rem_nx[VAL_W-1:0];
			quo_q  <= {quo_q[VAL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hw/rtl/piecewise_linear_interp_table_unit.sv]
// Piecewise linear interpolation table (uses pwl_pkg, pwl_cell and pwl_muldiv).
// Flow: clear, add and a query that misses on count or bounds go straight to the result;
// another query scans all POINT_DEPTH cells and then ends if no segment was found, gives a
// zero-width segment's left endpoint, or runs the 64-step divide. A stalled output waits.
// One request in flight: the next is taken the cycle after the result register loads.
// Reset (arst_n low) empties the table, sets the monotone flag and zeroes the bounds.
module piecewise_linear_interp_table_unit import pwl_pkg::*; #(
	parameter int unsigned POINT_DEPTH = DEF_POINT_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  pwl_req_t req,
	output logic     result_valid,
	input  logic     result_ready,
	output pwl_rsp_t result
);

	// The count must hold POINT_DEPTH itself; the scan step counter shares its width.
	localparam int unsigned CNT_W = $clog2(POINT_DEPTH + 1);

	pwl_state_t state_q, state_nx;

	logic [CNT_W-1:0]   count_q;
	logic               flag_q;
	logic signed [31:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;

	pwl_req_t           req_q;
	logic [CNT_W-1:0]   step_q;
	logic               found_q;
	logic signed [31:0] k0_q, k1_q, v0_q, v1_q;
	logic               neg_q;
	logic signed [31:0] res_q;
	logic               hit_q;
	logic               acc_q;
	pwl_rsp_t           result_q;
	logic               result_valid_q;

	logic accept;
	logic out_free;
	logic scan_en;
	logic start_div;
	logic pt_write;

	pwl_point_t cell_pt [POINT_DEPTH];
	pwl_point_t new_pt;

	// Request keys and the keys seen at the head of the chain.
	logic               inverse;
	logic signed [31:0] key;
	logic signed [31:0] head_k0, head_k1, head_v0, head_v1;
	logic               seg_hit;
	logic               query_ok;
	logic               last_step;

	logic signed [32:0] span;
	logic signed [32:0] diff;
	logic signed [32:0] offs;
	logic [VAL_W-1:0]   mag;
	logic               div_done;
	logic [VAL_W-1:0]   quo;

	assign accept   = req_valid && req_ready;
	assign out_free = !result_valid_q || result_ready;
	assign new_pt   = '{x: req.x_value, y: req.y_value};

	// An add stores its point when the table is empty, or when the curve still
	// rises and room remains.
	always_comb begin
		pt_write = 1'b0;
		if (accept && req.req_type == REQ_ADD) begin
			if (count_q == '0) begin
				pt_write = 1'b1;
			end else if (flag_q && req.y_value > y_hi_q &&
			             count_q < CNT_W'(POINT_DEPTH)) begin
				pt_write = 1'b1;
			end
		end
	end

	// The cells form a ring. During a query the whole ring rotates one place
	// per cycle, so the head always shows the next segment; after POINT_DEPTH
	// steps every point is back in its own cell.
	for (genvar i = 0; i < POINT_DEPTH; i++) begin : g_cell
		pwl_cell u_cell (
			.clk      (clk),
			.load_en  (pt_write && count_q == CNT_W'(i)),
			.load_pt  (new_pt),
			.shift_en (scan_en),
			.next_pt  (cell_pt[(i + 1) % POINT_DEPTH]),
			.pt       (cell_pt[i])
		);
	end

	assign inverse = (req_q.req_type == REQ_INV);
	assign key     = inverse ? req_q.y_value : req_q.x_value;
	assign head_k0 = inverse ? cell_pt[0].y : cell_pt[0].x;
	assign head_k1 = inverse ? cell_pt[1].y : cell_pt[1].x;
	assign head_v0 = inverse ? cell_pt[0].x : cell_pt[0].y;
	assign head_v1 = inverse ? cell_pt[1].x : cell_pt[1].y;

	// Only the first segment that brackets the key counts.
	assign seg_hit   = !found_q && ((step_q + 1'b1) < count_q) &&
	                   key >= head_k0 && key <= head_k1;
	assign last_step = (step_q == CNT_W'(POINT_DEPTH - 1));

	// A query with fewer than two points or a key outside the bounds misses at once.
	always_comb begin
		if (req.req_type == REQ_INV) begin
			query_ok = count_q >= CNT_W'(2) &&
			           req.y_value >= y_lo_q && req.y_value <= y_hi_q;
		end else begin
			query_ok = count_q >= CNT_W'(2) &&
			           req.x_value >= x_lo_q && req.x_value <= x_hi_q;
		end
	end

	assign span = 33'(k1_q) - 33'(k0_q);
	assign diff = 33'(v1_q) - 33'(v0_q);
	assign offs = 33'(key) - 33'(k0_q);
	assign mag  = diff[32] ? VAL_W'(-diff) : VAL_W'(diff);

	pwl_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_div),
		.a      (VAL_W'(offs)),
		.m      (mag),
		.b      (VAL_W'(span)),
		.done   (div_done),
		.quo    (quo)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((req.req_type == REQ_FWD || req.req_type == REQ_INV) && query_ok) begin
						state_nx = ST_SCAN;
					end else begin
						state_nx = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (last_step) begin
					state_nx = (found_q || seg_hit) ? ST_PREP : ST_DONE;
				end
			end
			ST_PREP: begin
				state_nx = (span == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req_ready = 1'b0;
		scan_en   = 1'b0;
		start_div = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_SCAN: scan_en   = 1'b1;
			ST_PREP: start_div = (span != '0);
			ST_DIV:  ;
			ST_DONE: ;
			default: ;
		endcase
	end

	// Control state: FSM, table count, flag, bounds and the output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			flag_q         <= 1'b1;
			x_lo_q         <= '0;
			x_hi_q         <= '0;
			y_lo_q         <= '0;
			y_hi_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (accept && req.req_type == REQ_CLEAR) begin
				count_q <= '0;
				flag_q  <= 1'b1;
				x_lo_q  <= '0;
				x_hi_q  <= '0;
				y_lo_q  <= '0;
				y_hi_q  <= '0;
			end else if (accept && req.req_type == REQ_ADD) begin
				if (count_q == '0) begin
					count_q <= CNT_W'(1);
					x_lo_q  <= req.x_value;
					x_hi_q  <= req.x_value;
					y_lo_q  <= req.y_value;
					y_hi_q  <= req.y_value;
				end else if (flag_q) begin
					if (req.y_value > y_hi_q) begin
						if (pt_write) begin
							count_q <= count_q + 1'b1;
							if (req.x_value < x_lo_q) x_lo_q <= req.x_value;
							if (req.x_value > x_hi_q) x_hi_q <= req.x_value;
							if (req.y_value < y_lo_q) y_lo_q <= req.y_value;
							y_hi_q <= req.y_value;
						end
					end else begin
						flag_q <= 1'b0;
					end
				end
			end
		end
	end

	// Request and segment datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			step_q  <= '0;
			found_q <= 1'b0;
			res_q   <= '0;
			hit_q   <= 1'b0;
			acc_q   <= pt_write;
		end
		if (scan_en) begin
			step_q <= step_q + 1'b1;
			if (seg_hit) begin
				found_q <= 1'b1;
				k0_q    <= head_k0;
				k1_q    <= head_k1;
				v0_q    <= head_v0;
				v1_q    <= head_v1;
			end
		end
		if (state_q == ST_PREP) begin
			neg_q <= diff[32];
			if (span == '0) begin
				// A zero-width segment gives its left endpoint.
				res_q <= v0_q;
				hit_q <= 1'b1;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			res_q <= neg_q ? (v0_q - $signed(quo)) : (v0_q + $signed(quo));
			hit_q <= 1'b1;
		end
		if (state_q == ST_DONE && out_free) begin
			result_q.result_value   <= res_q;
			result_q.hit            <= hit_q;
			result_q.accepted       <= acc_q;
			result_q.point_count    <= COUNT_OUT_W'(count_q);
			result_q.still_monotone <= flag_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
